// File: rtl/first_fit_variable_allocator_defines.svh
// Assertion macros for the first-fit allocator.
// Each macro expects clk and rst to be visible in the scope where it is used.
`ifndef FIRST_FIT_VARIABLE_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_VARIABLE_ALLOCATOR_DEFINES_SVH

// Same-cycle implication
`define FFVA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define FFVA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ffva_pkg.sv
// Shared types and constants of the first-fit allocator.
// Used by ffva_ctrl, ffva_dp and the top level; depends on nothing.
package ffva_pkg;

  localparam int POOL_WORDS_DEF = 1024;
  localparam int REQ_W          = 13;
  localparam int OFF_W          = 10;
  localparam int IN_TDATA_W     = 24;
  localparam int OUT_TDATA_W    = 16;
  localparam int WORD_BYTES     = 8;
  localparam int WORD_SHIFT     = 3;
  localparam int USED_FLAG      = 1;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Header memory read address source
  typedef enum logic [1:0] {
    RD_P   = 2'd0,
    RD_NXT = 2'd1,
    RD_N   = 2'd2,
    RD_OFF = 2'd3
  } rd_sel_t;

  // Header memory write kind
  typedef enum logic [2:0] {
    WR_NONE  = 3'd0,
    WR_INIT  = 3'd1,
    WR_MERGE = 3'd2,
    WR_TAKE  = 3'd3,
    WR_REST  = 3'd4,
    WR_FREE  = 3'd5
  } wr_sel_t;

  typedef struct packed {
    logic    load;
    logic    walk_n;
    logic    p_adv;
    logic    start_merge;
    logic    merge_step;
    logic    p_from_n;
    logic    rd_en;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    logic    res_load;
    logic    res_ok;
  } cmd_t;

  typedef struct packed {
    logic hdr_used;
    logic nxt_in;
    logic n_in;
    logic fit;
    logic split;
    logic q_in;
    logic off_ok;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/first_fit_variable_allocator.sv
// First-fit allocator with coalescing over a header memory; top level, uses ffva_pkg.
// A free checks its offset, then reads and rewrites its header (skipped for an offset
// outside the pool); an allocate reads headers, merges free followers, takes a fit and
// writes a split remainder header inside the pool. One item at a time; the next word is
// accepted the cycle after the result is loaded; loading waits while the last result is
// not taken. Reset (rst, synchronous): word 0 is written as one free block, then ready.
`include "first_fit_variable_allocator_defines.svh"

module first_fit_variable_allocator #(
  parameter int POOL_WORDS = ffva_pkg::POOL_WORDS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [12:0] request_bytes, [22:13] block_offset, [23] zero
  input  logic [ffva_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] operation
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [9:0] payload_offset, [15:10] zero
  output logic [ffva_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // [0] success
  output logic                             m_axis_tuser
);
  import ffva_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ffva_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_op    (s_axis_tuser),
    .sts      (sts),
    .cmd      (cmd)
  );

  ffva_dp #(
    .POOL_WORDS (POOL_WORDS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_axis_tdata),
    .in_op     (s_axis_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_flag  (m_axis_tuser)
  );

  // Checks
  `FFVA_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "accepted a word while busy")
  `FFVA_ASSERT_IMP(a_no_result_overwrite, cmd.res_load, !m_axis_tvalid || m_axis_tready, "result overwritten")
  `FFVA_ASSERT_IMP(a_fail_zero_offset, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0, "failure with offset")

endmodule

// File: rtl/ffva_ctrl.sv
// Controller of the first-fit allocator: walk, merge, split and free sequencing.
// Depends on ffva_pkg; drives the datapath ffva_dp through cmd_t / sts_t.
module ffva_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           in_op,
  input  ffva_pkg::sts_t sts,
  output ffva_pkg::cmd_t cmd
);
  import ffva_pkg::*;

  typedef enum logic [9:0] {
    S_INIT    = 10'b0000000001,
    S_IDLE    = 10'b0000000010,
    S_RD_P    = 10'b0000000100,
    S_CHK_P   = 10'b0000001000,
    S_MERGE   = 10'b0000010000,
    S_DECIDE  = 10'b0000100000,
    S_WR_REST = 10'b0001000000,
    S_F_RD    = 10'b0010000000,
    S_F_WR    = 10'b0100000000,
    S_DONE    = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic   ok, ok_next;

  // State and result flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      ok    <= 1'b0;
    end else begin
      state <= state_next;
      ok    <= ok_next;
    end
  end

  // Next state and commands
  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_P;
    cmd.wr_sel = WR_NONE;
    cmd.res_ok = ok;
    in_ready   = 1'b0;
    state_next = state;
    ok_next    = ok;
    unique case (state)
      S_INIT: begin
        cmd.wr_sel = WR_INIT;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = (in_op == OP_FREE) ? S_F_RD : S_RD_P;
        end
      end
      S_RD_P: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_P;
        state_next = S_CHK_P;
      end
      S_CHK_P: begin
        if (sts.hdr_used) begin
          // skip a used block
          cmd.p_adv = 1'b1;
          if (sts.nxt_in) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_NXT;
          end else begin
            ok_next    = 1'b0;
            state_next = S_DONE;
          end
        end else begin
          // free block: start merging its followers
          cmd.start_merge = 1'b1;
          if (sts.nxt_in) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_NXT;
            state_next = S_MERGE;
          end else begin
            state_next = S_DECIDE;
          end
        end
      end
      S_MERGE: begin
        cmd.walk_n = 1'b1;
        if (!sts.hdr_used) begin
          cmd.merge_step = 1'b1;
          if (sts.nxt_in) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_NXT;
          end else begin
            state_next = S_DECIDE;
          end
        end else begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.fit) begin
          cmd.wr_sel = WR_TAKE;
          ok_next    = 1'b1;
          state_next = (sts.split && sts.q_in) ? S_WR_REST : S_DONE;
        end else begin
          // keep the merged size and walk on
          cmd.wr_sel   = WR_MERGE;
          cmd.p_from_n = 1'b1;
          if (sts.n_in) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_N;
            state_next = S_CHK_P;
          end else begin
            ok_next    = 1'b0;
            state_next = S_DONE;
          end
        end
      end
      S_WR_REST: begin
        cmd.wr_sel = WR_REST;
        state_next = S_DONE;
      end
      S_F_RD: begin
        if (sts.off_ok) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_OFF;
          state_next = S_F_WR;
        end else begin
          ok_next    = 1'b0;
          state_next = S_DONE;
        end
      end
      S_F_WR: begin
        cmd.wr_sel = WR_FREE;
        ok_next    = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

endmodule

// File: rtl/ffva_dp.sv
// Datapath of the first-fit allocator: header memory, walk pointers, merge
// accumulator, fit and split arithmetic, result register. Depends on ffva_pkg.
module ffva_dp #(
  parameter int POOL_WORDS = ffva_pkg::POOL_WORDS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [ffva_pkg::IN_TDATA_W-1:0]  in_data,
  input  logic                             in_op,
  input  ffva_pkg::cmd_t                   cmd,
  output ffva_pkg::sts_t                   sts,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ffva_pkg::OUT_TDATA_W-1:0] out_data,
  output logic                             out_flag
);
  import ffva_pkg::*;

  localparam int AW     = $clog2(POOL_WORDS);
  localparam int PW     = AW + 2;
  localparam int HDR_W  = AW + 4;
  localparam int NEED_W = REQ_W + 1;
  localparam int CW     = ((HDR_W > NEED_W) ? HDR_W : NEED_W) + 1;
  localparam int QW     = ((PW > NEED_W) ? PW : NEED_W) + 1;
  localparam logic [HDR_W-1:0] HDR_INIT = HDR_W'((POOL_WORDS - 1) * WORD_BYTES);
  localparam logic [PW-1:0]    POOL_PTR = PW'(POOL_WORDS);

  logic [HDR_W-1:0]  mem [POOL_WORDS];
  logic [HDR_W-1:0]  hdr;
  logic [PW-1:0]     p, n, off_ptr;
  logic [HDR_W-1:0]  acc;
  logic [NEED_W-1:0] need;
  logic              op, off_ok;
  logic [OFF_W-1:0]  out_off;

  logic [REQ_W-1:0]  in_req;
  logic [OFF_W-1:0]  in_off, off_m1;
  logic [NEED_W-1:0] need_in;
  logic              off_ok_in;
  logic [HDR_W-1:0]  hdr_bytes, acc_sum, rest, take_val;
  logic [PW-1:0]     base, nxt;
  logic [QW-1:0]     q;
  logic [CW-1:0]     acc_c, need_c;
  logic              wr_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [HDR_W-1:0]  wr_data;

  // Input word decode
  assign in_req    = in_data[REQ_W-1:0];
  assign in_off    = in_data[REQ_W +: OFF_W];
  assign need_in   = (NEED_W'(in_req) + NEED_W'(WORD_BYTES - 1)) & ~NEED_W'(WORD_BYTES - 1);
  assign off_m1    = in_off - OFF_W'(1);
  assign off_ok_in = (in_off != '0) && (32'(off_m1) < 32'(POOL_WORDS));

  // Walk step: header after the one just read
  assign hdr_bytes = {hdr[HDR_W-1:1], 1'b0};
  assign base      = cmd.walk_n ? n : p;
  assign nxt       = base + PW'(1) + PW'(hdr >> WORD_SHIFT);
  assign acc_sum   = acc + HDR_W'(WORD_BYTES) + hdr_bytes;

  // Fit and split
  assign acc_c    = CW'(acc);
  assign need_c   = CW'(need);
  assign rest     = HDR_W'(acc_c - need_c - CW'(WORD_BYTES));
  assign q        = QW'(p) + QW'(1) + QW'(need >> WORD_SHIFT);
  assign take_val = (sts.split ? HDR_W'(need) : acc) | HDR_W'(USED_FLAG);

  always_comb begin
    sts.hdr_used = hdr[0];
    sts.nxt_in   = nxt < POOL_PTR;
    sts.n_in     = n < POOL_PTR;
    sts.fit      = acc_c >= need_c;
    sts.split    = acc_c >= need_c + CW'(WORD_BYTES);
    sts.q_in     = q < QW'(POOL_WORDS);
    sts.off_ok   = off_ok;
    sts.out_free = !out_valid || out_ready;
  end

  // Write port select
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = p[AW-1:0];
    wr_data = acc;
    unique case (cmd.wr_sel)
      WR_NONE: wr_en = 1'b0;
      WR_INIT: begin
        wr_addr = '0;
        wr_data = HDR_INIT;
      end
      WR_MERGE: wr_data = acc;
      WR_TAKE:  wr_data = take_val;
      WR_REST: begin
        wr_addr = q[AW-1:0];
        wr_data = rest;
      end
      WR_FREE: begin
        wr_addr = off_ptr[AW-1:0];
        wr_data = hdr_bytes;
      end
      default: wr_en = 1'b0;
    endcase
  end

  // Read port select
  always_comb begin
    unique case (cmd.rd_sel)
      RD_P:    rd_addr = p[AW-1:0];
      RD_NXT:  rd_addr = nxt[AW-1:0];
      RD_N:    rd_addr = n[AW-1:0];
      RD_OFF:  rd_addr = off_ptr[AW-1:0];
      default: rd_addr = p[AW-1:0];
    endcase
  end

  // Header memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      hdr <= mem[rd_addr];
    end
  end

  // Item registers, walk pointers and merge accumulator
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op      <= in_op;
      need    <= need_in;
      off_ptr <= PW'(off_m1);
      off_ok  <= off_ok_in;
      p       <= '0;
    end
    if (cmd.p_adv) begin
      p <= nxt;
    end
    if (cmd.p_from_n) begin
      p <= n;
    end
    if (cmd.start_merge) begin
      acc <= hdr_bytes;
      n   <= nxt;
    end
    if (cmd.merge_step) begin
      acc <= acc_sum;
      n   <= nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_flag <= cmd.res_ok;
      out_off  <= (cmd.res_ok && op == OP_ALLOC) ? OFF_W'(p + PW'(1)) : '0;
    end
  end

  assign out_data = OUT_TDATA_W'(out_off);

endmodule

// File: tb/first_fit_variable_allocator_tb.sv
// Self-checking bench for first_fit_variable_allocator: a heap predictor computes each
// result; a queue-fed driver sends and a clocked monitor checks each word. Depends on ffva_pkg.
`timescale 1ns / 100ps

module first_fit_variable_allocator_tb;
  import ffva_pkg::*;

  localparam int POOL        = POOL_WORDS_DEF;
  localparam int RAND_OPS    = 530;
  localparam int CYCLE_LIMIT = 6000000;

  typedef struct packed {
    logic             ok;
    logic [OFF_W-1:0] poff;
  } alloc_result_t;

  typedef struct {
    logic             op;
    logic [REQ_W-1:0] req;
    logic [OFF_W-1:0] off;
    bit               drain;
    alloc_result_t    want;
  } heap_req_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // [12:0] request_bytes, [22:13] block_offset, [23] zero
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  // [0] operation
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [9:0] payload_offset, [15:10] zero
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  // [0] success
  logic                   m_axis_tuser;

  // Shadow heap: header words and which words were ever written
  bit [13:0]     heap_words [POOL];
  bit            word_set   [POOL];
  int            set_words[$];
  int            live_offs[$];
  int            released_offs[$];

  heap_req_t     heap_cmds[$];
  alloc_result_t pending_results[$];
  heap_req_t     cur_cmd;
  heap_req_t     next_cmd;
  alloc_result_t want_res;
  logic          cmd_taken;
  int            gap_left;
  int            stall_left;
  int            stall_draw;
  int            acc_cnt;
  int            res_cnt;
  int            total_cmds;
  int            mismatches = 0;
  int unsigned   cycle_cnt = 0;

  first_fit_variable_allocator u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int hdr_bytes(int p);
    return int'(heap_words[p]) & ~USED_FLAG;
  endfunction

  function automatic int hdr_next(int p);
    return p + 1 + hdr_bytes(p) / WORD_BYTES;
  endfunction

  function automatic void put_hdr(int p, int v);
    heap_words[p] = 14'(v);
    if (!word_set[p]) begin
      word_set[p] = 1'b1;
      set_words.push_back(p);
    end
  endfunction

  function automatic int skip_busy(int p);
    while (p < POOL && heap_words[p][0])
      p = hdr_next(p);
    return p;
  endfunction

  // Fold every directly following free block into the free block at p
  function automatic void coalesce(int p);
    int n;
    if (p >= POOL)
      return;
    n = hdr_next(p);
    while (n < POOL && !heap_words[n][0]) begin
      put_hdr(p, int'(heap_words[p]) + WORD_BYTES + hdr_bytes(n));
      n = hdr_next(n);
    end
  endfunction

  // Apply one command to the shadow heap and return the result it must produce
  function automatic alloc_result_t predict_heap(logic op, logic [REQ_W-1:0] req,
                                                 logic [OFF_W-1:0] off);
    alloc_result_t r;
    int            need;
    int            p;
    int            rest;
    r = '0;
    if (op == OP_ALLOC) begin
      need = (int'(req) + WORD_BYTES - 1) & ~(WORD_BYTES - 1);
      p = skip_busy(0);
      coalesce(p);
      while (p < POOL && hdr_bytes(p) < need) begin
        p = skip_busy(hdr_next(p));
        coalesce(p);
      end
      if (p < POOL) begin
        // split off the tail when a header still fits there
        if (hdr_bytes(p) >= need + WORD_BYTES) begin
          rest = hdr_bytes(p) - need - WORD_BYTES;
          put_hdr(p, need);
          if (hdr_next(p) < POOL)
            put_hdr(hdr_next(p), rest);
        end
        put_hdr(p, int'(heap_words[p]) | USED_FLAG);
        r.ok   = 1'b1;
        r.poff = OFF_W'(p + 1);
      end
    end else if (off != '0) begin
      put_hdr(int'(off) - 1, int'(heap_words[int'(off) - 1]) & ~USED_FLAG);
      r.ok = 1'b1;
    end
    return r;
  endfunction

  task automatic queue_op(logic op, int req, int off, bit drain);
    heap_req_t c;
    c.op    = op;
    c.req   = REQ_W'(req);
    c.off   = OFF_W'(off);
    c.drain = drain;
    c.want  = predict_heap(c.op, c.req, c.off);
    if (op == OP_ALLOC && c.want.ok && c.want.poff != '0)
      live_offs.push_back(int'(c.want.poff));
    heap_cmds.push_back(c);
  endtask

  // Driver: present queued commands, random gaps, hold a drain command until idle
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      gap_left      <= $urandom_range(0, 18);
      acc_cnt       <= 0;
    end else begin
      cmd_taken = s_axis_tvalid && s_axis_tready;
      if (cmd_taken) begin
        pending_results.push_back(cur_cmd.want);
        acc_cnt <= acc_cnt + 1;
      end
      if (!s_axis_tvalid || cmd_taken) begin
        if (gap_left > 0) begin
          gap_left      <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (heap_cmds.size() > 0 &&
                     !(heap_cmds[0].drain && (cmd_taken || acc_cnt != res_cnt))) begin
          next_cmd = heap_cmds.pop_front();
          cur_cmd       <= next_cmd;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {1'b0, next_cmd.off, next_cmd.req};
          s_axis_tuser  <= next_cmd.op;
          gap_left      <= acc_cnt[6] ? 0 : $urandom_range(0, 18);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure, compare each result word with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left    <= $urandom_range(0, 18);
      res_cnt       <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      res_cnt <= res_cnt + 1;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got success %0b offset %0d",
                 $time, m_axis_tuser, m_axis_tdata[OFF_W-1:0]);
        mismatches++;
      end else begin
        want_res = pending_results.pop_front();
        if (m_axis_tuser !== want_res.ok) begin
          $display("%0t: success expected %0b got %0b", $time, want_res.ok, m_axis_tuser);
          mismatches++;
        end
        if (m_axis_tdata[OFF_W-1:0] !== want_res.poff) begin
          $display("%0t: payload_offset expected %0d got %0d", $time, want_res.poff,
                   m_axis_tdata[OFF_W-1:0]);
          mismatches++;
        end
      end
      stall_draw = res_cnt[5] ? 0 : $urandom_range(0, 18);
      stall_left    <= stall_draw;
      m_axis_tready <= (stall_draw == 0);
    end else if (!m_axis_tready) begin
      if (stall_left <= 1)
        m_axis_tready <= 1'b1;
      if (stall_left > 0)
        stall_left <= stall_left - 1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int sel;
    int sz;
    int idx;
    int off;
    int w;

    foreach (heap_words[i]) begin
      heap_words[i] = '0;
      word_set[i]   = 1'b0;
    end
    put_hdr(0, (POOL - 1) * WORD_BYTES);

    // Directed: whole pool, no fit, bad offset, double free
    queue_op(OP_ALLOC, 8184, 1023, 0);
    queue_op(OP_ALLOC, 0, 0, 0);
    queue_op(OP_FREE, 8184, 0, 0);
    queue_op(OP_FREE, 0, 1, 0);
    queue_op(OP_FREE, 0, 1, 0);
    // zero-byte request splits, then small blocks
    queue_op(OP_ALLOC, 0, 512, 0);
    queue_op(OP_ALLOC, 8, 0, 0);
    queue_op(OP_ALLOC, 1, 0, 0);
    queue_op(OP_FREE, 4095, 2, 0);
    queue_op(OP_FREE, 0, 4, 0);
    // merge three free blocks, then release a stale header inside a payload
    queue_op(OP_ALLOC, 16, 0, 0);
    queue_op(OP_FREE, 0, 4, 0);
    // leave a zero-size block on the last pool word and take it
    queue_op(OP_ALLOC, 8144, 0, 0);
    queue_op(OP_ALLOC, 0, 0, 1);
    queue_op(OP_ALLOC, 0, 0, 0);
    // failed walk keeps its merges
    queue_op(OP_FREE, 0, 5, 0);
    queue_op(OP_FREE, 0, 2, 0);
    queue_op(OP_ALLOC, 8184, 0, 0);
    queue_op(OP_ALLOC, 8168, 0, 0);
    queue_op(OP_FREE, 0, 2, 0);
    queue_op(OP_FREE, 0, 1, 0);
    queue_op(OP_ALLOC, 8, 0, 0);

    // Random: mostly alloc/free of live blocks, some double and stray frees
    for (int i = 0; i < RAND_OPS; i++) begin
      sel = $urandom_range(0, 99);
      if (live_offs.size() > 40)
        sel = (sel < 30) ? 0 : 60;
      if (live_offs.size() == 0 || sel < 55) begin
        sz = $urandom_range(0, 99);
        if (sz < 60)
          sz = $urandom_range(0, 96);
        else if (sz < 85)
          sz = $urandom_range(0, 640);
        else if (sz < 97)
          sz = $urandom_range(0, 8184);
        else
          sz = 8184;
        queue_op(OP_ALLOC, sz, $urandom_range(0, 1023), (i % 90) == 45);
      end else begin
        if (sel < 88 || (sel < 93 && released_offs.size() == 0)) begin
          idx = $urandom_range(0, live_offs.size() - 1);
          off = live_offs[idx];
          live_offs.delete(idx);
          released_offs.push_back(off);
          if (released_offs.size() > 16)
            void'(released_offs.pop_front());
        end else if (sel < 93) begin
          off = released_offs[$urandom_range(0, released_offs.size() - 1)];
        end else if (sel < 97) begin
          w   = set_words[$urandom_range(0, set_words.size() - 1)];
          off = (w < POOL - 1) ? w + 1 : 0;
        end else begin
          off = 0;
        end
        queue_op(OP_FREE, $urandom_range(0, 8184), off, (i % 90) == 45);
      end
    end
    total_cmds = heap_cmds.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (res_cnt != total_cmds)
      @(posedge clk);
    repeat (100) @(posedge clk);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
